// ----- src/lts_pkg.sv -----
// shared types and constants for the line tracking state machine
package lts_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned BUDGET_W = 24;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    localparam logic [BUDGET_W-1:0] IPL_RESET       = 24'd100;
    localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RESET = 8'd5;
    localparam logic [COUNT_W-1:0]  MIN_ENTRY_RESET = 16'd10;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = 16'hFFFF;

    // register indexes (word address)
    localparam logic [1:0] REG_IPL       = 2'd0;
    localparam logic [1:0] REG_MAX_LEVEL = 2'd1;
    localparam logic [1:0] REG_MIN_ENTRY = 2'd2;

    // commands
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_SETUP = 1'b1;

    // sensor codes
    localparam logic [1:0] CODE_MID   = 2'd0;
    localparam logic [1:0] CODE_RIGHT = 2'd1;
    localparam logic [1:0] CODE_LEFT  = 2'd2;
    localparam logic [1:0] CODE_NONE  = 2'd3;

    // on-line positions
    localparam logic [1:0] POS_LEFT  = 2'd0;
    localparam logic [1:0] POS_MID_L = 2'd1;
    localparam logic [1:0] POS_MID_R = 2'd2;
    localparam logic [1:0] POS_RIGHT = 2'd3;

    // single-bit sides
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // good entry side, with unknown
    localparam logic [1:0] GOOD_LEFT    = 2'd0;
    localparam logic [1:0] GOOD_RIGHT   = 2'd1;
    localparam logic [1:0] GOOD_UNKNOWN = 2'd2;

    typedef enum logic [2:0] {
        MODE_ON   = 3'd0,
        MODE_OFF  = 3'd1,
        MODE_GOOD = 3'd2,
        MODE_BAD  = 3'd3,
        MODE_OVER = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [1:0]         on_pos;
        logic               off_side;
        logic [1:0]         good_side;
        logic               bad_side;
        logic               over_side;
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] stable;
        logic [COUNT_W-1:0] entry;
    } t_state;

    // settings the step logic needs
    typedef struct packed {
        logic [LEVEL_W-1:0]  max_level;
        logic [COUNT_W-1:0]  min_entry;
        logic [BUDGET_W-1:0] budget;
    } t_step_cfg;

    // how the speed-up level moves on a processed sample
    typedef struct packed {
        logic inc;
        logic clr;
    } t_lvl_upd;

endpackage

// ----- src/line_tracking_state_machine.sv -----
// top level of the line tracking state machine
//
// Takes one 2-bit line sensor sample per transaction and returns one result
// transaction per sample: the tracking mode, every sub-position register, the
// speed-up level and the stability count after that sample. Throughput is one
// sample per clock while the result channel does not stall; a sample goes
// through one input register, then the state registers, which double as the
// result register. The next-state logic is a single shallow pass; the
// speed-up budget (iterations_per_level times level plus one) is kept as a
// running register, so no multiply sits in the sample path. A new sample is
// still taken into the input register while a finished result waits, as
// long as the input register is empty. The three configuration registers sit
// at byte addresses 0, 4 and 8 and should only be written while no sample is
// in flight.
module line_tracking_state_machine
    import lts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cmd,
    input  logic [1:0]          i_line_code,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_mode,
    output logic [1:0]          o_on_line_pos,
    output logic                o_off_line_side,
    output logic [1:0]          o_good_entry_side,
    output logic                o_bad_entry_side,
    output logic                o_over_entry_side,
    output logic [LEVEL_W-1:0]  o_speed_level,
    output logic [COUNT_W-1:0]  o_stable_count,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    // input register
    logic       r_in_valid;
    logic       r_in_cmd;
    logic [1:0] r_in_code;

    // tracking state, also the result register
    t_state     r_state;
    t_state     w_next;
    logic       r_out_valid;

    t_step_cfg  w_cfg;
    t_lvl_upd   w_upd_raw;
    t_lvl_upd   w_upd;
    logic       w_adv;   // result slot free or being emptied
    logic       w_fire;  // sample in the input register is processed

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    // level moves only count when the sample really commits
    assign w_upd.inc = w_upd_raw.inc && w_fire;
    assign w_upd.clr = w_upd_raw.clr && w_fire;

    lts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_level (r_state.level),
        .i_upd   (w_upd),
        .o_cfg   (w_cfg)
    );

    lts_step u_step (
        .i_cmd   (r_in_cmd),
        .i_code  (r_in_code),
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .o_state (w_next),
        .o_upd   (w_upd_raw)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd  <= i_cmd;
            r_in_code <= i_line_code;
        end
    end

    // state and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= MODE_OFF;
            r_state.on_pos    <= POS_LEFT;
            r_state.off_side  <= SIDE_RIGHT;
            r_state.good_side <= GOOD_LEFT;
            r_state.bad_side  <= SIDE_LEFT;
            r_state.over_side <= SIDE_LEFT;
            r_state.level     <= '0;
            r_state.stable    <= '0;
            r_state.entry     <= '0;
            r_out_valid       <= 1'b0;
        end else if (w_fire) begin
            r_state     <= w_next;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mode            = r_state.mode;
    assign o_on_line_pos     = r_state.on_pos;
    assign o_off_line_side   = r_state.off_side;
    assign o_good_entry_side = r_state.good_side;
    assign o_bad_entry_side  = r_state.bad_side;
    assign o_over_entry_side = r_state.over_side;
    assign o_speed_level     = r_state.level;
    assign o_stable_count    = r_state.stable;

    // a processed sample always leaves a result behind
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed sample produced no result");

    // state only moves when a sample is processed
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("tracking state changed without a sample");

    // set-up clears level and stability count
    a_setup_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd == CMD_SETUP)
        |=> (r_state.level == '0 && r_state.stable == '0))
        else $error("set-up did not clear level and stable count");

    // unknown good entry is sticky under step commands
    a_unknown_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_cmd == CMD_STEP && r_state.mode == MODE_GOOD
         && r_state.good_side == GOOD_UNKNOWN)
        |=> (r_state.mode == MODE_GOOD && r_state.good_side == GOOD_UNKNOWN))
        else $error("left unknown good entry without set-up");

endmodule

// ----- src/lts_cfg_regs.sv -----
// configuration registers and the running speed-up budget
module lts_cfg_regs
    import lts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic [LEVEL_W-1:0]   i_level,
    input  t_lvl_upd             i_upd,
    output t_step_cfg            o_cfg
);

    logic [COUNT_W-1:0]  r_ipl;
    logic [LEVEL_W-1:0]  r_max_level;
    logic [COUNT_W-1:0]  r_min_entry;
    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] n_budget;
    logic                w_wr;
    logic [1:0]          w_idx;
    logic [LEVEL_W:0]    w_lvl_p1;
    logic [COUNT_W+LEVEL_W:0] w_prod;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_idx    = paddr[3:2];
    assign w_lvl_p1 = {1'b0, i_level} + {{LEVEL_W{1'b0}}, 1'b1};
    // budget = iterations_per_level * (level + 1), only on a write
    assign w_prod   = {{(LEVEL_W+1){1'b0}}, pwdata[COUNT_W-1:0]}
                    * {{COUNT_W{1'b0}}, w_lvl_p1};

    always_comb begin
        n_budget = r_budget;
        if (w_wr && w_idx == REG_IPL) begin
            n_budget = w_prod[BUDGET_W-1:0];
        end else if (i_upd.clr) begin
            n_budget = {{(BUDGET_W-COUNT_W){1'b0}}, r_ipl};
        end else if (i_upd.inc) begin
            n_budget = r_budget + {{(BUDGET_W-COUNT_W){1'b0}}, r_ipl};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipl       <= IPL_RESET[COUNT_W-1:0];
            r_max_level <= MAX_LEVEL_RESET;
            r_min_entry <= MIN_ENTRY_RESET;
            r_budget    <= IPL_RESET;
        end else begin
            r_budget <= n_budget;
            if (w_wr) begin
                unique case (w_idx)
                    REG_IPL:       r_ipl       <= pwdata[COUNT_W-1:0];
                    REG_MAX_LEVEL: r_max_level <= pwdata[LEVEL_W-1:0];
                    REG_MIN_ENTRY: r_min_entry <= pwdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_IPL:       prdata = {{(DATA_W-COUNT_W){1'b0}}, r_ipl};
            REG_MAX_LEVEL: prdata = {{(DATA_W-LEVEL_W){1'b0}}, r_max_level};
            REG_MIN_ENTRY: prdata = {{(DATA_W-COUNT_W){1'b0}}, r_min_entry};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.max_level = r_max_level;
    assign o_cfg.min_entry = r_min_entry;
    assign o_cfg.budget    = r_budget;

endmodule

// ----- src/lts_step.sv -----
// next-state logic for one sensor sample
module lts_step
    import lts_pkg::*;
(
    input  logic       i_cmd,
    input  logic [1:0] i_code,
    input  t_state     i_state,
    input  t_step_cfg  i_cfg,
    output t_state     o_state,
    output t_lvl_upd   o_upd
);

    t_state     n;
    t_lvl_upd   upd;
    logic [1:0] target;
    logic       same;
    logic       crossing;
    logic       g_left;
    logic [1:0] own;

    always_comb begin
        n        = i_state;
        upd      = '0;
        target   = POS_LEFT;
        same     = 1'b0;
        crossing = 1'b0;
        g_left   = (i_state.good_side == GOOD_LEFT);
        own      = g_left ? CODE_LEFT : CODE_RIGHT;

        if (i_cmd == CMD_SETUP) begin
            n.stable = '0;
            n.level  = '0;
            upd.clr  = 1'b1;
            case (i_code)
                CODE_MID: begin
                    n.mode = MODE_ON; n.on_pos = POS_MID_L;
                end
                CODE_RIGHT: begin
                    n.mode = MODE_ON; n.on_pos = POS_RIGHT;
                end
                CODE_LEFT: begin
                    n.mode = MODE_ON; n.on_pos = POS_LEFT;
                end
                default: begin
                    n.mode = MODE_OFF; n.off_side = SIDE_RIGHT;
                end
            endcase
        end else begin
            unique case (i_state.mode)
                MODE_ON: begin
                    if (i_code == CODE_NONE) begin
                        n.stable = '0;
                        case (i_state.on_pos)
                            POS_LEFT: begin
                                n.level = '0; upd.clr = 1'b1;
                                n.mode = MODE_OFF; n.off_side = SIDE_LEFT;
                            end
                            POS_RIGHT: begin
                                n.level = '0; upd.clr = 1'b1;
                                n.mode = MODE_OFF; n.off_side = SIDE_RIGHT;
                            end
                            POS_MID_L: begin
                                n.mode = MODE_BAD; n.bad_side = SIDE_LEFT;
                            end
                            default: begin
                                n.mode = MODE_BAD; n.bad_side = SIDE_RIGHT;
                            end
                        endcase
                    end else begin
                        case (i_code)
                            CODE_MID: begin
                                target   = (i_state.on_pos == POS_RIGHT
                                            || i_state.on_pos == POS_MID_R)
                                           ? POS_MID_R : POS_MID_L;
                                same     = (i_state.on_pos == POS_MID_L
                                            || i_state.on_pos == POS_MID_R);
                                crossing = (i_state.on_pos == POS_LEFT
                                            || i_state.on_pos == POS_RIGHT);
                            end
                            CODE_RIGHT: begin
                                target   = POS_RIGHT;
                                same     = (i_state.on_pos == POS_RIGHT);
                                crossing = (i_state.on_pos == POS_MID_R);
                            end
                            default: begin
                                target   = POS_LEFT;
                                same     = (i_state.on_pos == POS_LEFT);
                                crossing = (i_state.on_pos == POS_MID_L);
                            end
                        endcase
                        n.mode = MODE_ON;
                        if (same) begin
                            if (i_state.stable != COUNT_MAX) begin
                                n.stable = i_state.stable + {{(COUNT_W-1){1'b0}}, 1'b1};
                            end
                        end else if (crossing) begin
                            // speed-up on a middle crossing; a stable count at or above the budget clears the level
                            if ({{(BUDGET_W-COUNT_W){1'b0}}, i_state.stable}
                                < i_cfg.budget) begin
                                if (i_state.level < i_cfg.max_level) begin
                                    n.level = i_state.level + {{(LEVEL_W-1){1'b0}}, 1'b1};
                                    upd.inc = 1'b1;
                                end
                            end else begin
                                n.level = '0;
                                upd.clr = 1'b1;
                            end
                            n.stable = '0;
                            n.on_pos = target;
                        end else begin
                            n.stable = '0;
                            n.on_pos = target;
                        end
                    end
                end
                MODE_OFF: begin
                    if (i_code != CODE_NONE) begin
                        if ((i_state.off_side == SIDE_LEFT && i_code == CODE_LEFT)
                            || (i_state.off_side == SIDE_RIGHT && i_code == CODE_RIGHT)) begin
                            n.mode      = MODE_GOOD;
                            n.good_side = {1'b0, i_state.off_side};
                        end else begin
                            n.mode     = MODE_BAD;
                            n.bad_side = i_state.off_side;
                        end
                    end
                end
                MODE_GOOD: begin
                    // unknown side holds until a set-up
                    if (i_state.good_side == GOOD_LEFT
                        || i_state.good_side == GOOD_RIGHT) begin
                        if (i_code == CODE_MID) begin
                            if (i_state.entry < i_cfg.min_entry) begin
                                n.mode     = MODE_BAD;
                                n.bad_side = i_state.good_side[0];
                            end else begin
                                n.mode   = MODE_ON;
                                n.on_pos = g_left ? POS_MID_L : POS_MID_R;
                            end
                            n.entry = '0;
                        end else if (i_code == own) begin
                            if (i_state.entry != COUNT_MAX) begin
                                n.entry = i_state.entry + {{(COUNT_W-1){1'b0}}, 1'b1};
                            end
                        end else if (i_code == CODE_NONE) begin
                            n.entry    = '0;
                            n.mode     = MODE_OFF;
                            n.off_side = i_state.good_side[0];
                        end else begin
                            n.entry     = '0;
                            n.good_side = GOOD_UNKNOWN;
                        end
                    end
                end
                MODE_BAD: begin
                    if (i_code == CODE_NONE) begin
                        n.mode      = MODE_OVER;
                        n.over_side = i_state.bad_side;
                    end
                end
                MODE_OVER: begin
                    case (i_code)
                        CODE_MID: begin
                            n.mode   = MODE_ON;
                            n.on_pos = (i_state.over_side == SIDE_LEFT)
                                       ? POS_MID_R : POS_MID_L;
                        end
                        CODE_RIGHT: begin
                            n.mode = MODE_ON; n.on_pos = POS_RIGHT;
                        end
                        CODE_LEFT: begin
                            n.mode = MODE_ON; n.on_pos = POS_LEFT;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_state = n;
    assign o_upd   = upd;

endmodule
